### sv/psl_pkg.sv
// Shared types and constants of the priority-sorted list with done flags.
package psl_pkg;

   localparam int DEPTH_DEFAULT  = 16;
   localparam int OP_W           = 2;
   localparam int PRIO_W         = 8;
   localparam int TAG_W          = 8;
   localparam int POS_W          = 4;
   localparam int STATUS_W       = 2;
   localparam int ENTRY_COUNT_W  = 5;
   localparam int POS_RANGE      = 1 << POS_W;

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 2'd0,
      OP_MARK  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } psl_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } psl_status_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]  tag;
      logic              done;
   } psl_entry_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      logic          insert;
      logic          mark;
      psl_entry_type entry;
   } psl_cmd_type;

endpackage

### sv/psl_cell.sv
// One cell of the sorted chain: holds one entry, keeps it, takes the new one or shifts, and sets done on a mark.
module psl_cell
   import psl_pkg::*;
(
   input  logic          clock,
   input  psl_cmd_type   cmd,
   input  logic          occupied,
   input  logic          mark_hit,
   input  logic          left_keeps,
   input  psl_entry_type left_entry,
   output logic          keeps,
   output psl_entry_type entry
);

   psl_entry_type entry_ff;
   psl_entry_type entry_in;

   // An occupied cell of equal or higher priority stays put; the new entry lands after it.
   assign keeps = occupied && (entry_ff.prio >= cmd.entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert && !keeps) begin
         entry_in = left_keeps ? cmd.entry : left_entry;
      end
      if (cmd.mark && mark_hit) begin
         entry_in.done = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### sv/priority_sorted_list_with_done_flags_unit.sv
// Priority-sorted list with done flags: top level with the cell chain and response register.
// The response to an accepted request is loaded into the output register in the cycle after it.
// Throughput: one transaction per cycle while responses are taken; every cell compares and shifts in parallel.
// A new request is taken while the response register is empty or being drained.
// Reset clears the entry count, the not-done count and the response valid;
// entry contents hold garbage until written and are never read unwritten.
module priority_sorted_list_with_done_flags_unit
   import psl_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OP_W-1:0]          req_operation,
   input  logic [PRIO_W-1:0]        req_new_priority,
   input  logic [TAG_W-1:0]         req_new_tag,
   input  logic                     req_new_done,
   input  logic [POS_W-1:0]         req_position,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic                     rsp_all_done,
   output logic [ENTRY_COUNT_W-1:0] rsp_entry_count,
   output logic [TAG_W-1:0]         rsp_read_tag,
   output logic [PRIO_W-1:0]        rsp_read_priority,
   output logic                     rsp_read_done
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int NREAD = (DEPTH < POS_RANGE) ? DEPTH : POS_RANGE;

   // Counters: entries held and entries held that are not yet done.
   logic [CNT_W-1:0] held_count_ff, held_count_in;
   logic [CNT_W-1:0] undone_count_ff, undone_count_in;

   // Response register.
   logic                     rsp_valid_ff, rsp_valid_in;
   psl_status_type           rsp_status_ff, rsp_status_in;
   logic                     rsp_all_done_ff;
   logic [ENTRY_COUNT_W-1:0] rsp_entry_count_ff;
   psl_entry_type            rsp_read_ff, rsp_read_in;

   logic          accept;
   psl_op_type    op;
   logic          full;
   logic          pos_ok;
   psl_entry_type rd_entry;
   psl_cmd_type   cmd;

   logic [DEPTH-1:0] cell_keeps;
   logic [DEPTH-1:0] cell_occupied;
   logic [DEPTH-1:0] cell_mark_hit;
   psl_entry_type    cell_entry [DEPTH];

   // Drain-or-empty handshake: the response register parts the two sides.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign op        = psl_op_type'(req_operation);
   assign full      = (held_count_ff == CNT_W'(DEPTH));
   assign pos_ok    = CMP_W'(req_position) < CMP_W'(held_count_ff);

   // Broadcast command; drop a full add or an out-of-range mark here.
   always_comb begin
      cmd.insert     = accept && (op == OP_ADD) && !full;
      cmd.mark       = accept && (op == OP_MARK) && pos_ok;
      cmd.entry.prio = req_new_priority;
      cmd.entry.tag  = req_new_tag;
      cmd.entry.done = req_new_done;
   end

   // Chain of cells: each looks at its left neighbor only.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_occupied[i] = CNT_W'(i) < held_count_ff;
      if (i < POS_RANGE) begin : g_hit
         assign cell_mark_hit[i] = (req_position == POS_W'(i));
      end else begin : g_nohit
         assign cell_mark_hit[i] = 1'b0;
      end
      if (i == 0) begin : g_head
         psl_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occupied   (cell_occupied[i]),
            .mark_hit   (cell_mark_hit[i]),
            .left_keeps (1'b1),
            .left_entry (cmd.entry),
            .keeps      (cell_keeps[i]),
            .entry      (cell_entry[i])
         );
      end else begin : g_body
         psl_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occupied   (cell_occupied[i]),
            .mark_hit   (cell_mark_hit[i]),
            .left_keeps (cell_keeps[i-1]),
            .left_entry (cell_entry[i-1]),
            .keeps      (cell_keeps[i]),
            .entry      (cell_entry[i])
         );
      end
   end

   // Select the entry at the requested position; only the first cells are addressable.
   always_comb begin
      rd_entry = '0;
      for (int i = 0; i < NREAD; i++) begin
         if (req_position == POS_W'(i)) begin
            rd_entry = cell_entry[i];
         end
      end
   end

   // Next counts: track not-done entries so all_done needs no scan of the chain.
   always_comb begin
      held_count_in   = held_count_ff;
      undone_count_in = undone_count_ff;
      if (accept && (op == OP_CLEAR)) begin
         held_count_in   = '0;
         undone_count_in = '0;
      end else if (cmd.insert) begin
         held_count_in = held_count_ff + CNT_W'(1);
         if (!req_new_done) begin
            undone_count_in = undone_count_ff + CNT_W'(1);
         end
      end else if (cmd.mark && !rd_entry.done) begin
         undone_count_in = undone_count_ff - CNT_W'(1);
      end
   end

   // Response contents for this transaction.
   always_comb begin
      rsp_status_in = ST_OK;
      rsp_read_in   = '0;
      case (op)
         OP_ADD: begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end
         end
         OP_MARK: begin
            if (!pos_ok) begin
               rsp_status_in = ST_RANGE;
            end
         end
         OP_READ: begin
            if (pos_ok) begin
               rsp_read_in = rd_entry;
            end else begin
               rsp_status_in = ST_RANGE;
            end
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
   end

   // Hold the response until taken; load a new one on accept.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff   <= '0;
         undone_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         held_count_ff   <= held_count_in;
         undone_count_ff <= undone_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff      <= rsp_status_in;
         rsp_all_done_ff    <= (undone_count_in == '0);
         rsp_entry_count_ff <= ENTRY_COUNT_W'(held_count_in);
         rsp_read_ff        <= rsp_read_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_all_done      = rsp_all_done_ff;
   assign rsp_entry_count   = rsp_entry_count_ff;
   assign rsp_read_tag      = rsp_read_ff.tag;
   assign rsp_read_priority = rsp_read_ff.prio;
   assign rsp_read_done     = rsp_read_ff.done;

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   a_undone_bound : assert property (@(posedge clock) disable iff (reset)
      undone_count_ff <= held_count_ff)
      else $error("not-done count exceeds entry count");

   a_full_status : assert property (@(posedge clock) disable iff (reset)
      accept && (op == OP_ADD) && full |=> rsp_status_ff == ST_FULL
         && held_count_ff == CNT_W'(DEPTH))
      else $error("full add changed the list or was not flagged");

   a_clear_done : assert property (@(posedge clock) disable iff (reset)
      accept && (op == OP_CLEAR) |=> rsp_all_done_ff && held_count_ff == '0)
      else $error("clear left entries behind");
`endif

endmodule
